/* rtl/asp_pkg.sv */
// ----------------------------------------------------------------------------
// asp_pkg: shared types, constants and pattern test for the sleep package
// extractor.
// Holds the AML opcodes, the window type and the function that tests one
// start position of the byte window.
// ----------------------------------------------------------------------------
package asp_pkg;

  // Window geometry: the longest match spans eighteen bytes.
  localparam int WIN_DEPTH = 18;
  localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
  localparam int IDX_W     = $clog2(WIN_DEPTH);

  // Configuration register indexes.
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_TYPE_A = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_DEF_TYPE_B = 1'b1;

  // AML bytes of the root-prefixed _S5_ name and the package opcodes.
  localparam logic [7:0] AML_ROOT     = 8'h5C;
  localparam logic [7:0] AML_UNDER    = 8'h5F;
  localparam logic [7:0] AML_CHAR_S   = 8'h53;
  localparam logic [7:0] AML_CHAR_5   = 8'h35;
  localparam logic [7:0] AML_NAME_OP  = 8'h08;
  localparam logic [7:0] AML_PKG_OP   = 8'h12;
  localparam logic [7:0] AML_BYTE_PFX = 8'h0A;
  localparam logic [7:0] AML_WORD_PFX = 8'h0B;
  localparam logic [7:0] AML_ZERO_OP  = 8'h00;
  localparam logic [7:0] AML_ONE_OP   = 8'h01;
  localparam logic [7:0] MIN_ELEMENTS = 8'h02;

  // PM1 control word: sleep enable bit.
  localparam logic [15:0] SLP_EN_BIT = 16'h2000;

  typedef enum logic [1:0] {
    ST_RUN,
    ST_DRAIN
  } asp_state_e;

  typedef logic [WIN_DEPTH-1:0][7:0] win_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic drain;
    logic clear;
    logic load;
  } asp_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic fill_zero;
  } asp_status_t;

  typedef struct packed {
    logic            ok;
    logic [15:0]     val;
    logic [IDX_W-1:0] next;
  } int_res_t;

  typedef struct packed {
    logic        ok;
    logic [15:0] type_a;
    logic [15:0] type_b;
  } test_res_t;

  // Parse one integer constant at position q; fails if absent or cut off.
  function automatic int_res_t take_int(win_t w, logic [IDX_W-1:0] q,
                                        logic [FILL_W-1:0] avail);
    int_res_t r;
    r.ok   = 1'b0;
    r.val  = '0;
    r.next = q;
    if (FILL_W'(q) < avail) begin
      case (w[q])
        AML_BYTE_PFX: begin
          if (FILL_W'(q) + FILL_W'(1) < avail) begin
            r.ok   = 1'b1;
            r.val  = {8'h00, w[q + IDX_W'(1)]};
            r.next = q + IDX_W'(2);
          end
        end
        AML_WORD_PFX: begin
          if (FILL_W'(q) + FILL_W'(2) < avail) begin
            r.ok   = 1'b1;
            r.val  = {w[q + IDX_W'(2)], w[q + IDX_W'(1)]};
            r.next = q + IDX_W'(3);
          end
        end
        AML_ZERO_OP: begin
          r.ok   = 1'b1;
          r.val  = 16'h0000;
          r.next = q + IDX_W'(1);
        end
        AML_ONE_OP: begin
          r.ok   = 1'b1;
          r.val  = 16'h0001;
          r.next = q + IDX_W'(1);
        end
        default: r.ok = 1'b0;
      endcase
    end
    return r;
  endfunction

  // Test the start position at the head of the window, avail bytes valid.
  function automatic test_res_t test_at(win_t w, logic [FILL_W-1:0] avail);
    test_res_t        r;
    logic             head_ok;
    logic [IDX_W-1:0] pos;
    int_res_t         ia;
    int_res_t         ib;
    head_ok = (w[0] == AML_ROOT)   && (w[1] == AML_UNDER) &&
              (w[2] == AML_CHAR_S) && (w[3] == AML_CHAR_5) &&
              (w[4] == AML_UNDER)  && (w[5] == AML_NAME_OP) &&
              (w[6] == AML_PKG_OP) && (avail >= FILL_W'(8));
    // Bits 7:6 of the PkgLength lead byte count the extra length bytes.
    pos  = IDX_W'(8) + IDX_W'(w[7][7:6]);
    ia   = take_int(w, pos + IDX_W'(1), avail);
    ib   = take_int(w, ia.next, avail);
    r.ok = head_ok && (FILL_W'(pos) < avail) && (w[pos] >= MIN_ELEMENTS) &&
           ia.ok && ib.ok;
    r.type_a = ia.val;
    r.type_b = ib.val;
    return r;
  endfunction

endpackage

/* rtl/asp_ctrl.sv */
// ----------------------------------------------------------------------------
// asp_ctrl: sequencing controller of the sleep package extractor.
// Runs the byte stream, drains the window after the last byte and hands
// the result to the output register once that register is free.
// ----------------------------------------------------------------------------
module asp_ctrl
  import asp_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        last_byte_i,
  input  logic        out_ready_i,
  input  asp_status_t status_i,
  output logic        in_ready_o,
  output logic        out_valid_o,
  output asp_cmd_t    cmd_o
);

  asp_state_e state_q, state_d;
  logic       full_q, full_d;
  logic       slot_free;

  // The output register can take a result when empty or emptied this cycle.
  assign slot_free = !full_q || out_ready_i;

  // State register and output register occupancy.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_RUN;
      full_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      full_q  <= full_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_RUN: begin
        if (in_valid_i && last_byte_i) state_d = ST_DRAIN;
      end
      ST_DRAIN: begin
        if (status_i.fill_zero && slot_free) state_d = ST_RUN;
      end
      default: state_d = ST_RUN;
    endcase
  end

  // Handshakes and datapath commands.
  always_comb begin
    in_ready_o   = 1'b0;
    cmd_o        = '0;
    case (state_q)
      ST_RUN: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_DRAIN: begin
        cmd_o.drain = !status_i.fill_zero;
        if (status_i.fill_zero && slot_free) begin
          cmd_o.load  = 1'b1;
          cmd_o.clear = 1'b1;
        end
      end
      default: begin
        in_ready_o = 1'b0;
      end
    endcase
  end

  // A loaded result stays on offer until it is taken.
  assign full_d      = cmd_o.load || (full_q && !out_ready_i);
  assign out_valid_o = full_q;

  // A waiting result is held until it is taken.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> out_valid_o)
    else $error("result dropped before it was taken");

  // A result is loaded only into a free output register.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |-> (!out_valid_o || out_ready_i))
    else $error("waiting result overwritten");

  // A last byte always leads into the drain.
  a_last_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_byte_i) |=> !in_ready_o)
    else $error("last byte did not start the drain");

  // Loading the result reopens the input.
  a_reopen: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.load |=> in_ready_o)
    else $error("input not reopened after result");

endmodule

/* rtl/asp_dpath.sv */
// ----------------------------------------------------------------------------
// asp_dpath: byte window, pattern test and result registers.
// Keeps the eighteen-byte window, tests its head position and holds the
// first matched sleep types and the configured defaults.
// ----------------------------------------------------------------------------
module asp_dpath
  import asp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  asp_cmd_t             cmd_i,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i,
  output asp_status_t          status_o,
  output logic                 found_o,
  output logic [15:0]          sleep_type_a_o,
  output logic [15:0]          sleep_type_b_o,
  output logic [15:0]          control_word_a_o,
  output logic [15:0]          control_word_b_o
);

  win_t              win_q, win_d;
  logic [FILL_W-1:0] fill_q, fill_d;
  logic              match_q, match_d;
  logic [15:0]       held_a_q, held_a_d;
  logic [15:0]       held_b_q, held_b_d;
  logic [15:0]       def_a_q;
  logic [15:0]       def_b_q;
  logic              res_found_q;
  logic [15:0]       res_a_q;
  logic [15:0]       res_b_q;
  win_t              test_win;
  logic [FILL_W-1:0] test_avail;
  test_res_t         res;
  logic [15:0]       type_a;
  logic [15:0]       type_b;

  // During the stream the test sees the incoming byte at the window tail.
  always_comb begin
    if (cmd_i.drain) begin
      test_win   = win_q;
      test_avail = fill_q;
    end else begin
      test_win   = win_t'({data_byte_i, win_q[WIN_DEPTH-2:0]});
      test_avail = FILL_W'(WIN_DEPTH);
    end
    res = test_at(test_win, test_avail);
  end

  // Window, fill count and first-match capture.
  always_comb begin
    win_d    = win_q;
    fill_d   = fill_q;
    match_d  = match_q;
    held_a_d = held_a_q;
    held_b_d = held_b_q;
    if (cmd_i.clear) begin
      fill_d   = '0;
      match_d  = 1'b0;
      held_a_d = '0;
      held_b_d = '0;
    end else if (cmd_i.drain) begin
      if (!match_q && res.ok) begin
        match_d  = 1'b1;
        held_a_d = res.type_a;
        held_b_d = res.type_b;
      end
      win_d  = win_t'(win_q >> 8);
      fill_d = fill_q - FILL_W'(1);
    end else if (cmd_i.accept) begin
      if (!last_byte_i && (fill_q == FILL_W'(WIN_DEPTH - 1))) begin
        // Full window: test the oldest position, then retire it.
        if (!match_q && res.ok) begin
          match_d  = 1'b1;
          held_a_d = res.type_a;
          held_b_d = res.type_b;
        end
        win_d = win_t'(test_win >> 8);
      end else begin
        win_d[fill_q[IDX_W-1:0]] = data_byte_i;
        fill_d                   = fill_q + FILL_W'(1);
      end
    end
  end

  // Control registers of the stream.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q   <= '0;
      match_q  <= 1'b0;
      held_a_q <= '0;
      held_b_q <= '0;
    end else begin
      fill_q   <= fill_d;
      match_q  <= match_d;
      held_a_q <= held_a_d;
      held_b_q <= held_b_d;
    end
  end

  // Window bytes beyond the fill count are never looked at.
  always_ff @(posedge clk_i) begin
    win_q <= win_d;
  end

  // Default sleep type registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      def_a_q <= 16'd7;
      def_b_q <= 16'd7;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEF_TYPE_A: def_a_q <= cfg_data_i;
        CFG_DEF_TYPE_B: def_b_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Sleep types of the finished table: matched values or the defaults.
  assign type_a = match_q ? held_a_q : def_a_q;
  assign type_b = match_q ? held_b_q : def_b_q;

  // Output register, loaded once the drain is over, so that the next
  // table can stream in while the result waits.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_found_q <= 1'b0;
      res_a_q     <= '0;
      res_b_q     <= '0;
    end else if (cmd_i.load) begin
      res_found_q <= match_q;
      res_a_q     <= type_a;
      res_b_q     <= type_b;
    end
  end

  // Result fields and PM1 control words.
  assign found_o          = res_found_q;
  assign sleep_type_a_o   = res_a_q;
  assign sleep_type_b_o   = res_b_q;
  assign control_word_a_o = {res_a_q[5:0], 10'b0} | SLP_EN_BIT;
  assign control_word_b_o = {res_b_q[5:0], 10'b0} | SLP_EN_BIT;
  assign status_o.fill_zero = (fill_q == '0);

  // The window never holds more bytes than it has room for.
  a_fill_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_q <= FILL_W'(WIN_DEPTH))
    else $error("window overfilled");

  // Once a match is held it stays until the next clear.
  a_match_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (match_q && !cmd_i.clear) |=> (match_q && $stable(held_a_q) && $stable(held_b_q)))
    else $error("held match changed");

  // A clear empties the window and drops the match.
  a_clear: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.clear |=> (fill_q == '0) && !match_q)
    else $error("clear did not empty the stream state");

  // A result is loaded only after every position has been tested.
  a_load_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load |-> (fill_q == '0))
    else $error("result loaded before the drain finished");

endmodule

/* rtl/aml_sleep_package_extractor.sv */
// ----------------------------------------------------------------------------
// aml_sleep_package_extractor: S5 sleep type finder for an AML byte stream.
// Scans table bytes for the root _S5_ package and reports its two sleep
// types, or the configured defaults, with the PM1 control words.
//
//   Channel  | Signals                                        | Direction
//   ---------+------------------------------------------------+----------
//   input    | in_valid_i, in_ready_o, data_byte_i, last_byte_i | in
//   output   | out_valid_o, out_ready_i, found_o, sleep_type_*, | out
//            | control_word_*                                  |
//   config   | cfg_we_i, cfg_idx_i, cfg_data_i                 | in
//
// Stream bytes are taken one per cycle while the input is open; the window
// test at its head is combinational. After the last byte the window is
// drained one position a cycle until no pending byte is left, then the
// result is loaded; the input is closed from the last byte until that
// load. The result waits in an output register, so the next table
// streams in meanwhile; only the end of that table's drain waits for the
// request on the output to be accepted. Reset returns the stream state to
// empty and both defaults to 7.
// ----------------------------------------------------------------------------
module aml_sleep_package_extractor
  import asp_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [7:0]           data_byte_i,
  input  logic                 last_byte_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 found_o,
  output logic [15:0]          sleep_type_a_o,
  output logic [15:0]          sleep_type_b_o,
  output logic [15:0]          control_word_a_o,
  output logic [15:0]          control_word_b_o,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [15:0]          cfg_data_i
);

  asp_cmd_t    cmd;
  asp_status_t status;

  // Sequencing controller.
  asp_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .last_byte_i (last_byte_i),
    .out_ready_i (out_ready_i),
    .status_i    (status),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .cmd_o       (cmd)
  );

  // Window and result datapath.
  asp_dpath u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i),
    .status_o         (status),
    .found_o          (found_o),
    .sleep_type_a_o   (sleep_type_a_o),
    .sleep_type_b_o   (sleep_type_b_o),
    .control_word_a_o (control_word_a_o),
    .control_word_b_o (control_word_b_o)
  );

endmodule

/* tb/aml_sleep_scoreboard_pkg.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aml_sleep_scoreboard_pkg: result prediction for the S5 sleep type finder.
// Follows the byte window of the block request by request, works out the
// result expected at the end of each table and compares the results that
// the block returns against it, field by field and in order.
// ----------------------------------------------------------------------------
package aml_sleep_scoreboard_pkg;
  import asp_pkg::*;

  // One result of the block: flag, both sleep types and both control words.
  typedef struct packed {
    logic        found;
    logic [15:0] type_a;
    logic [15:0] type_b;
    logic [15:0] word_a;
    logic [15:0] word_b;
  } sleep_result_t;

  class sleep_scoreboard;
    logic [7:0]    win [WIN_DEPTH];
    int unsigned   fill;
    bit            hit;
    logic [15:0]   held_a;
    logic [15:0]   held_b;
    logic [15:0]   dflt_a;
    logic [15:0]   dflt_b;
    sleep_result_t expected_q [$];
    int unsigned   bytes_seen;
    int unsigned   results_seen;
    int unsigned   found_seen;
    int unsigned   fail_count;

    function new();
      dflt_a       = 16'd7;
      dflt_b       = 16'd7;
      bytes_seen   = 0;
      results_seen = 0;
      found_seen   = 0;
      fail_count   = 0;
      clear_table();
    endfunction

    // Forget everything about the current table; the defaults are kept.
    function void clear_table();
      foreach (win[i]) win[i] = 8'h00;
      fill   = 0;
      hit    = 1'b0;
      held_a = 16'h0000;
      held_b = 16'h0000;
    endfunction

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] value);
      if (idx == CFG_DEF_TYPE_A) dflt_a = value;
      else if (idx == CFG_DEF_TYPE_B) dflt_b = value;
    endfunction

    // Decode one integer constant at offset pos from base; fails when the
    // opcode is not an integer or its operand bytes are not yet in.
    function bit read_const(int unsigned base, int unsigned avail,
                            inout int unsigned pos, output logic [15:0] value);
      value = 16'h0000;
      if (pos >= avail) return 1'b0;
      case (win[base + pos])
        AML_BYTE_PFX: begin
          if (pos + 1 >= avail) return 1'b0;
          value = {8'h00, win[base + pos + 1]};
          pos += 2;
        end
        AML_WORD_PFX: begin
          if (pos + 2 >= avail) return 1'b0;
          value = {win[base + pos + 2], win[base + pos + 1]};
          pos += 3;
        end
        AML_ZERO_OP: begin
          pos += 1;
        end
        AML_ONE_OP: begin
          value = 16'h0001;
          pos += 1;
        end
        default: return 1'b0;
      endcase
      return 1'b1;
    endfunction

    // Try a package starting at window position k; only the first one counts.
    function void probe(int unsigned k);
      int unsigned avail;
      int unsigned pos;
      logic [15:0] va;
      logic [15:0] vb;
      if (hit || k >= fill) return;
      avail = fill - k;
      if (avail < 8) return;
      if (win[k] != AML_ROOT || win[k + 1] != AML_UNDER || win[k + 2] != AML_CHAR_S ||
          win[k + 3] != AML_CHAR_5 || win[k + 4] != AML_UNDER ||
          win[k + 5] != AML_NAME_OP || win[k + 6] != AML_PKG_OP) return;
      // The top two bits of the length lead byte count the extra length bytes.
      pos = 8 + win[k + 7][7:6];
      if (pos >= avail) return;
      if (win[k + pos] < MIN_ELEMENTS) return;
      pos++;
      if (!read_const(k, avail, pos, va)) return;
      if (!read_const(k, avail, pos, vb)) return;
      hit    = 1'b1;
      held_a = va;
      held_b = vb;
    endfunction

    function logic [15:0] control_word(logic [15:0] sleep_type);
      return (sleep_type << 10) | SLP_EN_BIT;
    endfunction

    // Note one accepted request; the last byte of a table queues a result.
    function void note_byte(logic [7:0] data, logic last);
      sleep_result_t r;
      logic [15:0]   ta;
      logic [15:0]   tb;
      bytes_seen++;
      if (fill < WIN_DEPTH) begin
        win[fill] = data;
        fill++;
      end
      if (!last) begin
        if (fill >= WIN_DEPTH) begin
          probe(0);
          for (int i = 0; i < WIN_DEPTH - 1; i++) win[i] = win[i + 1];
          win[WIN_DEPTH - 1] = 8'h00;
          fill = WIN_DEPTH - 1;
        end
        return;
      end
      // End of table: every position still pending is tried in order.
      for (int k = 0; k < fill; k++) probe(k);
      ta = hit ? held_a : dflt_a;
      tb = hit ? held_b : dflt_b;
      r.found  = hit;
      r.type_a = ta;
      r.type_b = tb;
      r.word_a = control_word(ta);
      r.word_b = control_word(tb);
      expected_q.push_back(r);
      clear_table();
    endfunction

    function void report(string what, sleep_result_t want, sleep_result_t got);
      fail_count++;
      if (fail_count <= 10)
        $display("%0t: %s: expected found=%0d a=%h b=%h cw_a=%h cw_b=%h, got found=%0d a=%h b=%h cw_a=%h cw_b=%h",
                 $time, what, want.found, want.type_a, want.type_b, want.word_a,
                 want.word_b, got.found, got.type_a, got.type_b, got.word_a, got.word_b);
    endfunction

    // Compare one accepted result with the oldest expectation.
    function void check_result(sleep_result_t got);
      sleep_result_t want;
      results_seen++;
      if (expected_q.size() == 0) begin
        report("result with none expected", '0, got);
        return;
      end
      want = expected_q.pop_front();
      if (want.found) found_seen++;
      if (got.found !== want.found || got.type_a !== want.type_a ||
          got.type_b !== want.type_b || got.word_a !== want.word_a ||
          got.word_b !== want.word_b)
        report("result mismatch", want, got);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction
  endclass

endpackage

/* tb/aml_sleep_package_extractor_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// aml_sleep_package_extractor_test: testbench for the S5 sleep type finder.
// Streams AML tables, mostly with embedded _S5_ packages of random content,
// some broken or cut short, under several default settings, with random
// sender gaps and receiver stalls, and checks every result against a model.
// ----------------------------------------------------------------------------
module aml_sleep_package_extractor_test;
  import asp_pkg::*;
  import aml_sleep_scoreboard_pkg::*;

  localparam int unsigned BYTE_TARGET    = 1900;
  localparam int unsigned SETTLE_CYCLES  = 24;
  localparam int unsigned WATCHDOG_LIMIT = 1000;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 in_valid_i;
  logic                 in_ready_o;
  logic [7:0]           data_byte_i;
  logic                 last_byte_i;
  logic                 out_valid_o;
  logic                 out_ready_i;
  logic                 found_o;
  logic [15:0]          sleep_type_a_o;
  logic [15:0]          sleep_type_b_o;
  logic [15:0]          control_word_a_o;
  logic [15:0]          control_word_b_o;
  logic                 cfg_we_i;
  logic [CFG_IDX_W-1:0] cfg_idx_i;
  logic [15:0]          cfg_data_i;

  sleep_scoreboard sb = new();

  logic [7:0]  tbl [$];
  int unsigned burst_left;
  int unsigned send_mode;
  int unsigned stall_mode;
  int unsigned stall_left;
  int unsigned idle_cycles;
  int unsigned tables_sent;
  int unsigned settings_used;

  aml_sleep_package_extractor dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_ready_o       (in_ready_o),
    .data_byte_i      (data_byte_i),
    .last_byte_i      (last_byte_i),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .found_o          (found_o),
    .sleep_type_a_o   (sleep_type_a_o),
    .sleep_type_b_o   (sleep_type_b_o),
    .control_word_a_o (control_word_a_o),
    .control_word_b_o (control_word_b_o),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_data_i       (cfg_data_i)
  );

  // Clock generation.
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Monitor: register writes, accepted requests and accepted results.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_reg(cfg_idx_i, cfg_data_i);
      if (in_valid_i && in_ready_o) sb.note_byte(data_byte_i, last_byte_i);
      if (out_valid_o && out_ready_i)
        sb.check_result({found_o, sleep_type_a_o, sleep_type_b_o,
                         control_word_a_o, control_word_b_o});
    end
  end

  // Watchdog: ends the run when no request moves for too long.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Timeout: no request accepted for %0d cycles", WATCHDOG_LIMIT);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: stalls on its own pattern, chosen per phase.
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      stall_left  <= 0;
    end else if (stall_left != 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else begin
      out_ready_i <= 1'b1;
      if (stall_mode == 1 && $urandom_range(0, 7) == 0)
        stall_left <= $urandom_range(1, 4);
      else if (stall_mode == 2 && $urandom_range(0, 1) == 0)
        stall_left <= $urandom_range(1, 20);
    end
  end

  // Offer one byte, idling first when the current burst is used up.
  task automatic send_byte(input logic [7:0] data, input logic last);
    int unsigned gap;
    if (burst_left == 0) begin
      case (send_mode)
        0:       gap = 0;
        1:       gap = $urandom_range(0, 3);
        default: gap = $urandom_range(0, 10);
      endcase
      if (gap != 0) begin
        @(negedge clk_i);
        in_valid_i <= 1'b0;
        repeat (gap - 1) @(negedge clk_i);
      end
      burst_left = $urandom_range(1, 16);
    end
    burst_left--;
    @(negedge clk_i);
    in_valid_i  <= 1'b1;
    data_byte_i <= data;
    last_byte_i <= last;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic send_table();
    foreach (tbl[i]) send_byte(tbl[i], i == tbl.size() - 1);
    tables_sent++;
  endtask

  // Wait until every result is in, then let the block settle.
  task automatic settle();
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_defaults(input logic [15:0] type_a, input logic [15:0] type_b);
    @(negedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_DEF_TYPE_A;
    cfg_data_i <= type_a;
    @(negedge clk_i);
    cfg_idx_i  <= CFG_DEF_TYPE_B;
    cfg_data_i <= type_b;
    @(negedge clk_i);
    cfg_we_i   <= 1'b0;
    settings_used++;
  endtask

  // Sixteen-bit value leaning towards the extremes.
  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 5))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(0, 7));
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Noise is half random bytes and half pattern bytes, to make near misses.
  task automatic add_noise(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 1) == 0) begin
        tbl.push_back(8'($urandom_range(0, 255)));
      end else begin
        case ($urandom_range(0, 9))
          0:       tbl.push_back(AML_ROOT);
          1:       tbl.push_back(AML_UNDER);
          2:       tbl.push_back(AML_CHAR_S);
          3:       tbl.push_back(AML_CHAR_5);
          4:       tbl.push_back(AML_NAME_OP);
          5:       tbl.push_back(AML_PKG_OP);
          6:       tbl.push_back(AML_BYTE_PFX);
          7:       tbl.push_back(AML_WORD_PFX);
          8:       tbl.push_back(AML_ZERO_OP);
          default: tbl.push_back(AML_ONE_OP);
        endcase
      end
    end
  endtask

  task automatic add_head();
    tbl.push_back(AML_ROOT);
    tbl.push_back(AML_UNDER);
    tbl.push_back(AML_CHAR_S);
    tbl.push_back(AML_CHAR_5);
    tbl.push_back(AML_UNDER);
    tbl.push_back(AML_NAME_OP);
    tbl.push_back(AML_PKG_OP);
  endtask

  task automatic add_const();
    logic [15:0] value;
    value = pick_word();
    case ($urandom_range(0, 3))
      0: begin
        tbl.push_back(AML_BYTE_PFX);
        tbl.push_back(value[7:0]);
      end
      1: begin
        tbl.push_back(AML_WORD_PFX);
        tbl.push_back(value[7:0]);
        tbl.push_back(value[15:8]);
      end
      2:       tbl.push_back(AML_ZERO_OP);
      default: tbl.push_back(AML_ONE_OP);
    endcase
  endtask

  // A package with random length encoding and content, sometimes damaged.
  task automatic add_package();
    int unsigned start;
    logic [7:0]  lead;
    start = tbl.size();
    add_head();
    lead = 8'($urandom_range(0, 255));
    tbl.push_back(lead);
    repeat (lead[7:6]) tbl.push_back(8'($urandom_range(0, 255)));
    if ($urandom_range(0, 7) == 0) tbl.push_back(8'($urandom_range(0, 1)));
    else if ($urandom_range(0, 3) == 0) tbl.push_back(MIN_ELEMENTS);
    else tbl.push_back(8'($urandom_range(2, 255)));
    add_const();
    add_const();
    if ($urandom_range(0, 4) == 0)
      tbl[$urandom_range(start, tbl.size() - 1)] = 8'($urandom_range(0, 255));
  endtask

  task automatic build_table();
    int unsigned cut;
    tbl.delete();
    if ($urandom_range(0, 3) == 0) add_noise($urandom_range(0, 40));
    else add_noise($urandom_range(0, 12));
    if ($urandom_range(0, 9) != 0) add_package();
    if ($urandom_range(0, 3) == 0) add_package();
    add_noise($urandom_range(0, 6));
    // Cut the tail now and then so that a package runs off the end.
    if ($urandom_range(0, 5) == 0) begin
      cut = $urandom_range(1, 6);
      while (tbl.size() > 1 && cut != 0) begin
        void'(tbl.pop_back());
        cut--;
      end
    end
    if (tbl.size() == 0) tbl.push_back(8'($urandom_range(0, 255)));
  endtask

  // Stimulus sequence.
  initial begin
    int unsigned phase;
    int unsigned tables_left;
    logic [15:0] dflt_a;
    logic [15:0] dflt_b;
    rst_ni        = 1'b0;
    in_valid_i    = 1'b0;
    data_byte_i   = 8'h00;
    last_byte_i   = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_idx_i     = CFG_DEF_TYPE_A;
    cfg_data_i    = 16'h0000;
    burst_left    = 0;
    send_mode     = 0;
    stall_mode    = 0;
    tables_sent   = 0;
    settings_used = 1;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed tables with the reset defaults: a single byte, a package that
    // ends exactly on the last byte, and a package cut off by the end.
    tbl = '{8'hFF};
    send_table();
    tbl.delete();
    add_head();
    tbl.push_back(8'h05);
    tbl.push_back(MIN_ELEMENTS);
    tbl.push_back(AML_ZERO_OP);
    tbl.push_back(AML_WORD_PFX);
    tbl.push_back(8'hFF);
    tbl.push_back(8'hFF);
    send_table();
    tbl.delete();
    add_head();
    tbl.push_back(8'h40);
    tbl.push_back(8'h00);
    tbl.push_back(MIN_ELEMENTS);
    tbl.push_back(AML_BYTE_PFX);
    send_table();
    settle();

    // Random tables, in phases with their own defaults and idling pattern.
    phase = 1;
    while (sb.bytes_seen < BYTE_TARGET) begin
      case (phase)
        1: begin
          dflt_a = 16'h0000;
          dflt_b = 16'hFFFF;
        end
        2: begin
          dflt_a = 16'hFFFF;
          dflt_b = 16'h0000;
        end
        default: begin
          dflt_a = pick_word();
          dflt_b = pick_word();
        end
      endcase
      write_defaults(dflt_a, dflt_b);
      send_mode   = $urandom_range(0, 2);
      stall_mode  = $urandom_range(0, 2);
      tables_left = $urandom_range(6, 10);
      while (tables_left != 0 && sb.bytes_seen < BYTE_TARGET) begin
        build_table();
        send_table();
        tables_left--;
      end
      settle();
      phase++;
    end

    $display("Summary: %0d bytes in %0d tables under %0d default settings.",
             sb.bytes_seen, tables_sent, settings_used);
    $display("Summary: %0d results checked, %0d with a package found, %0d mismatches.",
             sb.results_seen, sb.found_seen, sb.fail_count);
    if (sb.fail_count == 0 && sb.pending() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
